// ===== design/rpx_pkg.sv =====
// Shared widths, constants, types and the restoring divide step for the rainbow pixel block.
`default_nettype none

package rpx_pkg;

    // Field and register widths
    localparam int IDX_W      = 10;
    localparam int PERIOD_W   = 10;
    localparam int STEP_W     = 8;
    localparam int PCT_W      = 7;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // Internal widths
    localparam int SUM_W     = IDX_W + 1;   // index + phase, phase + step
    localparam int FRAC_W    = 17;          // 0 .. 65536 (16 fractional bits)
    localparam int HUE_W     = 17;          // 0 .. 92160 (8 fractional bits)
    localparam int SCALED_W  = 27;          // position * 360 * 256
    localparam int SECREM_W  = 14;          // remainder inside one sector
    localparam int FRAC16_W  = 16;          // fraction inside one sector

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HUE_PERIOD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_SATURATION = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE      = CFG_IDX_W'(3);

    // Register reset values
    localparam logic [PERIOD_W-1:0] HUE_PERIOD_RST = PERIOD_W'(30);
    localparam logic [STEP_W-1:0]   PHASE_STEP_RST = STEP_W'(4);
    localparam logic [PCT_W-1:0]    PCT_RST        = PCT_W'(100);
    localparam logic [PERIOD_W-1:0] PERIOD_MIN     = PERIOD_W'(2);

    // Job queue depth between the front and back parts
    localparam int QUEUE_DEPTH_DEF = 2;

    // Fixed-point constants
    localparam int                 SECTORS      = 6;
    localparam logic [HUE_W-1:0]   HUE_SCALE    = HUE_W'(92160);    // 360 * 256
    localparam logic [HUE_W-1:0]   SECTOR_WIDTH = HUE_W'(15360);    // 60 * 256
    localparam logic [FRAC_W-1:0]  FRAC_ONE     = FRAC_W'(65536);
    localparam logic [PCT_W-1:0]   PCT_MAX      = PCT_W'(100);
    // pct * 65536 / 100 as a multiply by a rounded-up reciprocal (exact for pct <= 100)
    localparam int                 PCT_RECIP_W  = 22;
    localparam logic [PCT_RECIP_W-1:0] PCT_RECIP = PCT_RECIP_W'(2684355);
    localparam int                 PCT_SHIFT    = 12;
    // rem * 65536 / 15360 = rem * 64 / 15, same scheme (exact for rem < 15360)
    localparam int                 FRAC_RECIP_W = 21;
    localparam logic [FRAC_RECIP_W-1:0] FRAC_RECIP = FRAC_RECIP_W'(1118482);
    localparam int                 FRAC_SHIFT   = 18;

    // Hue sectors, red through yellow, green, cyan, blue, magenta; hue 360 wraps
    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5,
        SEC_WRAP    = 3'd6
    } sector_t;

    // Live configuration, period already clamped
    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [STEP_W-1:0]   phase_step;
        logic [PCT_W-1:0]    saturation_pct;
        logic [PCT_W-1:0]    value_pct;
    } rpx_ctl_t;

    // One job handed from the front to the back
    typedef struct packed {
        logic [IDX_W-1:0]    pixel_index;
        logic [PERIOD_W-1:0] pos;
    } rpx_job_t;

    typedef struct packed {
        logic                qbit;
        logic [PERIOD_W-1:0] rem;
    } div_step_t;

    // One restoring division step: shift in a dividend bit, subtract if it fits
    function automatic div_step_t div_step(input logic [PERIOD_W-1:0] rem,
                                           input logic                din,
                                           input logic [PERIOD_W-1:0] divisor);
        logic [PERIOD_W:0] trial;
        logic [PERIOD_W:0] diff;
        div_step_t         res;
        trial = {rem, din};
        diff  = trial - {1'b0, divisor};
        if (trial >= {1'b0, divisor})
        begin
            res.qbit = 1'b1;
            res.rem  = diff[PERIOD_W-1:0];
        end
        else
        begin
            res.qbit = 1'b0;
            res.rem  = trial[PERIOD_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== design/rpx_if.sv =====
// Valid/ready channel interfaces for LED index items and colour items.
`default_nettype none

interface rpx_led_if;
    import rpx_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] led_index;
    logic             frame_end;
    modport source (output valid, led_index, frame_end, input ready);
    modport sink   (input valid, led_index, frame_end, output ready);
endinterface

interface rpx_colour_if;
    import rpx_pkg::*;
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  pixel_index;
    logic [BYTE_W-1:0] green_byte;
    logic [BYTE_W-1:0] red_byte;
    logic [BYTE_W-1:0] blue_byte;
    modport source (output valid, pixel_index, green_byte, red_byte, blue_byte, input ready);
    modport sink   (input valid, pixel_index, green_byte, red_byte, blue_byte, output ready);
endinterface

`default_nettype wire

// ===== design/rpx_front.sv =====
// Front part: takes an LED item, reduces index + phase mod period, frame end advances phase.
`default_nettype none

module rpx_front (
    input  logic               clk,
    input  logic               rst_n,
    input  rpx_pkg::rpx_ctl_t  ctl,
    rpx_led_if.sink            led,
    output logic               job_valid,
    input  logic               job_ready,
    output rpx_pkg::rpx_job_t  job_data
);
    import rpx_pkg::*;

    localparam int CNT_W = $clog2(SUM_W);

    typedef enum logic [2:0] {
        FR_IDLE   = 3'b001,
        FR_DIVIDE = 3'b010,
        FR_PUSH   = 3'b100
    } fr_state_t;

    fr_state_t           state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [PERIOD_W-1:0] phase_reg, phase_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                fend_reg, fend_next;
    // lane a: position, lane b: next phase
    logic [SUM_W-1:0]    a_div_reg, a_div_next, b_div_reg, b_div_next;
    logic [PERIOD_W-1:0] a_rem_reg, a_rem_next, b_rem_reg, b_rem_next;
    div_step_t           st_a, st_b;

    assign st_a = div_step(a_rem_reg, a_div_reg[SUM_W-1], ctl.period);
    assign st_b = div_step(b_rem_reg, b_div_reg[SUM_W-1], ctl.period);

    assign led.ready            = (state_reg == FR_IDLE);
    assign job_valid            = (state_reg == FR_PUSH);
    assign job_data.pixel_index = idx_reg;
    assign job_data.pos         = a_rem_reg;

    // Sequencer: accept, eleven remainder steps on both lanes, hand over
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        idx_next   = idx_reg;
        fend_next  = fend_reg;
        a_div_next = a_div_reg;
        b_div_next = b_div_reg;
        a_rem_next = a_rem_reg;
        b_rem_next = b_rem_reg;
        case (state_reg)
            FR_IDLE:
            begin
                if (led.valid)
                begin
                    idx_next   = led.led_index;
                    fend_next  = led.frame_end;
                    a_div_next = SUM_W'(led.led_index) + SUM_W'(phase_reg);
                    b_div_next = SUM_W'(phase_reg) + SUM_W'(ctl.phase_step);
                    a_rem_next = '0;
                    b_rem_next = '0;
                    cnt_next   = '0;
                    state_next = FR_DIVIDE;
                end
            end
            FR_DIVIDE:
            begin
                a_div_next = {a_div_reg[SUM_W-2:0], 1'b0};
                b_div_next = {b_div_reg[SUM_W-2:0], 1'b0};
                a_rem_next = st_a.rem;
                b_rem_next = st_b.rem;
                cnt_next   = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(SUM_W - 1))
                begin
                    if (fend_reg)
                        phase_next = st_b.rem;
                    state_next = FR_PUSH;
                end
            end
            FR_PUSH:
            begin
                if (job_ready)
                    state_next = FR_IDLE;
            end
            default:
            begin
                state_next = FR_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_IDLE;
            cnt_reg   <= '0;
            phase_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        fend_reg  <= fend_next;
        a_div_reg <= a_div_next;
        b_div_reg <= b_div_next;
        a_rem_reg <= a_rem_next;
        b_rem_reg <= b_rem_next;
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (led.valid && led.ready) |=> (state_reg == FR_DIVIDE && cnt_reg == '0))
        else $error("front did not start the remainder after an accepted item");

endmodule

`default_nettype wire

// ===== design/rpx_fifo.sv =====
// Short job queue between the front and back parts.
`default_nettype none

module rpx_fifo #(
    parameter int DEPTH = rpx_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  rpx_pkg::rpx_job_t  push_data,
    output logic               pop_valid,
    input  logic               pop_ready,
    output rpx_pkg::rpx_job_t  pop_data
);
    import rpx_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rpx_job_t         slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer wrap and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("job queue fill count beyond its depth");

    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("job queue count did not fall on a pop");

endmodule

`default_nettype wire

// ===== design/rpx_back.sv =====
// Back part: hue division, sector split, chroma products and byte conversion.
`default_nettype none

module rpx_back (
    input  logic               clk,
    input  logic               rst_n,
    input  rpx_pkg::rpx_ctl_t  ctl,
    input  logic               job_valid,
    output logic               job_ready,
    input  rpx_pkg::rpx_job_t  job_data,
    rpx_colour_if.source       colour
);
    import rpx_pkg::*;

    localparam int CNT_W      = $clog2(SCALED_W);
    localparam int PCT_PROD_W = PCT_W + PCT_RECIP_W;
    localparam int FR_PROD_W  = SECREM_W + FRAC_RECIP_W;
    localparam int MUL_W      = 2 * FRAC_W;
    localparam int BYTE_PROD_W = FRAC_W + BYTE_W;

    typedef enum logic [6:0] {
        BK_IDLE   = 7'b0000001,
        BK_SCALE  = 7'b0000010,
        BK_DIVIDE = 7'b0000100,
        BK_SECTOR = 7'b0001000,
        BK_FRAC   = 7'b0010000,
        BK_XMUL   = 7'b0100000,
        BK_MIX    = 7'b1000000
    } bk_state_t;

    // Percent to a fraction with 16 fractional bits, clamped at 100
    function automatic logic [FRAC_W-1:0] pct_to_frac(input logic [PCT_W-1:0] pct);
        logic [PCT_W-1:0]      p;
        logic [PCT_PROD_W-1:0] prod;
        p    = (pct > PCT_MAX) ? PCT_MAX : pct;
        prod = PCT_PROD_W'(p) * PCT_PROD_W'(PCT_RECIP);
        return prod[PCT_SHIFT +: FRAC_W];
    endfunction

    // floor(f * 255 / 65536)
    function automatic logic [BYTE_W-1:0] to_byte(input logic [FRAC_W-1:0] f);
        logic [BYTE_PROD_W-1:0] t;
        t = {f, {BYTE_W{1'b0}}} - BYTE_PROD_W'(f);
        return t[FRAC_W-1 +: BYTE_W];
    endfunction

    // Sector number by comparison against the sector edges
    function automatic sector_t hue_sector(input logic [HUE_W-1:0] hue);
        logic [2:0] n;
        n = '0;
        for (int k = 1; k <= SECTORS; k++)
        begin
            if (hue >= HUE_W'(k * 15360))
                n = n + 3'd1;
        end
        return sector_t'(n);
    endfunction

    bk_state_t             state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [PERIOD_W-1:0]   pos_reg, pos_next;
    logic [SCALED_W-1:0]   quo_reg, quo_next;
    logic [PERIOD_W-1:0]   rem_reg, rem_next;
    sector_t               sector_reg, sector_next;
    logic [SECREM_W-1:0]   secrem_reg, secrem_next;
    logic [FRAC16_W-1:0]   frac_reg, frac_next;
    logic [FRAC_W-1:0]     x_reg, x_next;
    logic [FRAC_W-1:0]     sf_reg, vf_reg, c_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]      out_idx_reg, out_idx_next;
    logic [BYTE_W-1:0]     out_g_reg, out_g_next, out_r_reg, out_r_next, out_b_reg, out_b_next;

    logic [PERIOD_W-1:0]   divisor;
    div_step_t             st;
    logic [HUE_W-1:0]      hue;
    sector_t               sec;
    logic [HUE_W-1:0]      sec_base;
    logic [MUL_W-1:0]      c_prod;
    logic [FR_PROD_W-1:0]  fr_prod;
    logic [FRAC_W-1:0]     factor;
    logic [MUL_W-1:0]      x_prod;
    logic [FRAC_W-1:0]     m_lvl;
    logic [FRAC_W-1:0]     r_cmp, g_cmp, b_cmp;
    logic                  out_free;

    // Saturation, value and chroma follow the registers, one product per stage
    assign c_prod = MUL_W'(sf_reg) * MUL_W'(vf_reg);
    assign m_lvl  = vf_reg - c_reg;

    always_ff @(posedge clk)
    begin
        sf_reg <= pct_to_frac(ctl.saturation_pct);
        vf_reg <= pct_to_frac(ctl.value_pct);
        c_reg  <= c_prod[FRAC16_W +: FRAC_W];
    end

    // Hue divider step, sector split and fraction product
    assign divisor  = ctl.period - PERIOD_W'(1);
    assign st       = div_step(rem_reg, quo_reg[SCALED_W-1], divisor);
    assign hue      = quo_reg[HUE_W-1:0];
    assign sec      = hue_sector(hue);
    assign sec_base = HUE_W'(sec) * SECTOR_WIDTH;
    assign fr_prod  = FR_PROD_W'(secrem_reg) * FR_PROD_W'(FRAC_RECIP);
    assign factor   = sector_reg[0] ? (FRAC_ONE - FRAC_W'(frac_reg)) : FRAC_W'(frac_reg);
    assign x_prod   = MUL_W'(c_reg) * MUL_W'(factor);

    // Route chroma and secondary component to the channels
    always_comb
    begin
        case (sector_reg)
            SEC_RED_YEL: begin r_cmp = c_reg; g_cmp = x_reg; b_cmp = '0;    end
            SEC_YEL_GRN: begin r_cmp = x_reg; g_cmp = c_reg; b_cmp = '0;    end
            SEC_GRN_CYN: begin r_cmp = '0;    g_cmp = c_reg; b_cmp = x_reg; end
            SEC_CYN_BLU: begin r_cmp = '0;    g_cmp = x_reg; b_cmp = c_reg; end
            SEC_BLU_MAG: begin r_cmp = x_reg; g_cmp = '0;    b_cmp = c_reg; end
            default:     begin r_cmp = c_reg; g_cmp = '0;    b_cmp = x_reg; end
        endcase
    end

    assign out_free  = !out_valid_reg || colour.ready;
    assign job_ready = (state_reg == BK_IDLE);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        sector_next    = sector_reg;
        secrem_next    = secrem_reg;
        frac_next      = frac_reg;
        x_next         = x_reg;
        out_valid_next = out_valid_reg && !colour.ready;
        out_idx_next   = out_idx_reg;
        out_g_next     = out_g_reg;
        out_r_next     = out_r_reg;
        out_b_next     = out_b_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    idx_next   = job_data.pixel_index;
                    pos_next   = job_data.pos;
                    state_next = BK_SCALE;
                end
            end
            BK_SCALE:
            begin
                quo_next   = SCALED_W'(pos_reg) * SCALED_W'(HUE_SCALE);
                rem_next   = '0;
                cnt_next   = '0;
                state_next = BK_DIVIDE;
            end
            BK_DIVIDE:
            begin
                quo_next = {quo_reg[SCALED_W-2:0], st.qbit};
                rem_next = st.rem;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(SCALED_W - 1))
                    state_next = BK_SECTOR;
            end
            BK_SECTOR:
            begin
                sector_next = sec;
                secrem_next = SECREM_W'(hue - sec_base);
                state_next  = BK_FRAC;
            end
            BK_FRAC:
            begin
                frac_next  = fr_prod[FRAC_SHIFT +: FRAC16_W];
                state_next = BK_XMUL;
            end
            BK_XMUL:
            begin
                x_next     = x_prod[FRAC16_W +: FRAC_W];
                state_next = BK_MIX;
            end
            BK_MIX:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = idx_reg;
                    out_g_next     = to_byte(g_cmp + m_lvl);
                    out_r_next     = to_byte(r_cmp + m_lvl);
                    out_b_next     = to_byte(b_cmp + m_lvl);
                    state_next     = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath and output register
    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        pos_reg     <= pos_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        sector_reg  <= sector_next;
        secrem_reg  <= secrem_next;
        frac_reg    <= frac_next;
        x_reg       <= x_next;
        out_idx_reg <= out_idx_next;
        out_g_reg   <= out_g_next;
        out_r_reg   <= out_r_next;
        out_b_reg   <= out_b_next;
    end

    assign colour.valid       = out_valid_reg;
    assign colour.pixel_index = out_idx_reg;
    assign colour.green_byte  = out_g_reg;
    assign colour.red_byte    = out_r_reg;
    assign colour.blue_byte   = out_b_reg;

    a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (job_valid && job_ready) |=> (state_reg == BK_SCALE))
        else $error("back part did not start on a popped job");

    a_mix_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_MIX && out_free) |=> (out_valid_reg && state_reg == BK_IDLE))
        else $error("finished colour did not reach the output register");

endmodule

`default_nettype wire

// ===== design/rainbow_pixel_hsv_to_rgb.sv =====
// Top level of the rainbow pixel generator: configuration registers, front, queue and back.
//
//  Channel  | Kind        | Payload                                          | Handshake
//  ---------+-------------+--------------------------------------------------+-------------
//  led      | item in     | led_index[9:0], frame_end                        | valid/ready
//  colour   | item out    | pixel_index[9:0], green/red/blue_byte[7:0]       | valid/ready
//  cfg      | reg write   | cfg_index[1:0], cfg_data[9:0]                    | cfg_wr_en
//
// The back part works through pop, scale, the bit-serial hue divider, sector, fraction,
// secondary product and mix for each item, and takes a new job only once the last is done.
// The front runs its 11 remainder steps and then runs ahead on the next item while the
// queue has room.
// Reset loads the register defaults and clears the phase; no clearing pass is needed.
// A two-entry job queue and the output register let either side stall on its own.
`default_nettype none

module rainbow_pixel_hsv_to_rgb #(
    parameter int QUEUE_DEPTH = rpx_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    rpx_led_if.sink                         led,
    rpx_colour_if.source                    colour,
    input  logic                            cfg_wr_en,
    input  logic [rpx_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rpx_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rpx_pkg::*;

    logic [PERIOD_W-1:0] hue_period_reg;
    logic [STEP_W-1:0]   phase_step_reg;
    logic [PCT_W-1:0]    saturation_reg;
    logic [PCT_W-1:0]    value_reg;
    rpx_ctl_t            ctl;
    logic                fr_valid, fr_ready, bk_valid, bk_ready;
    rpx_job_t            fr_job, bk_job;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_period_reg <= HUE_PERIOD_RST;
            phase_step_reg <= PHASE_STEP_RST;
            saturation_reg <= PCT_RST;
            value_reg      <= PCT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_HUE_PERIOD: hue_period_reg <= cfg_data[PERIOD_W-1:0];
                CFG_PHASE_STEP: phase_step_reg <= cfg_data[STEP_W-1:0];
                CFG_SATURATION: saturation_reg <= cfg_data[PCT_W-1:0];
                CFG_VALUE:      value_reg      <= cfg_data[PCT_W-1:0];
                default: ;
            endcase
        end
    end

    // Periods below two act as two
    assign ctl.period         = (hue_period_reg < PERIOD_MIN) ? PERIOD_MIN : hue_period_reg;
    assign ctl.phase_step     = phase_step_reg;
    assign ctl.saturation_pct = saturation_reg;
    assign ctl.value_pct      = value_reg;

    rpx_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .led       (led),
        .job_valid (fr_valid),
        .job_ready (fr_ready),
        .job_data  (fr_job)
    );

    rpx_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_data  (fr_job),
        .pop_valid  (bk_valid),
        .pop_ready  (bk_ready),
        .pop_data   (bk_job)
    );

    rpx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .job_valid (bk_valid),
        .job_ready (bk_ready),
        .job_data  (bk_job),
        .colour    (colour)
    );

endmodule

`default_nettype wire
